>>> rtl/cwsm_pkg.sv
// Shared types and constants for the centered window sum/mean block.
// No dependencies; every other file uses this package.
`default_nettype none
package cwsm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RESULT_W = 23;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;
  // Wide enough for the largest ring index and window count in range
  localparam int SLOT_W   = 9;
  localparam int CNT_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_MODE = 1'd1;

  typedef enum logic {
    CMD_WRITE,
    CMD_JOB
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                last;
    logic                mean;
    logic [SLOT_W-1:0]   slot;    // write slot, or first slot of the window
    logic [CNT_W-1:0]    cnt;     // samples in the window
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef enum logic {
    F_ACCEPT,
    F_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

>>> rtl/cwsm_in_if.sv
// Sample channel: valid/ready handshake with sample and last flag.
// Uses cwsm_pkg for the field widths.
`default_nettype none
interface cwsm_in_if;
  logic                           valid;
  logic                           ready;
  logic [cwsm_pkg::SAMPLE_W-1:0]  sample;
  logic                           last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface
`default_nettype wire

>>> rtl/cwsm_out_if.sv
// Result channel: valid/ready handshake with result value and last flag.
// Uses cwsm_pkg for the field widths.
`default_nettype none
interface cwsm_out_if;
  logic                           valid;
  logic                           ready;
  logic [cwsm_pkg::RESULT_W-1:0]  result_value;
  logic                           last_result;
  modport source (output valid, result_value, last_result, input ready);
  modport sink (input valid, result_value, last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/cwsm_queue.sv
// Short command queue between the front and back parts.
// Depends on cwsm_pkg for the command type.
`default_nettype none
module cwsm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cwsm_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output cwsm_pkg::cmd_t     pop_data,
  output logic               empty
);
  import cwsm_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  cmd_t           mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // store word on push
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !push) |=> empty) else $error("queue went nonempty without push");
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> !empty) else $error("push lost");

endmodule
`default_nettype wire

>>> rtl/cwsm_front.sv
// Front part: accepts samples, tracks sequence position and issues ring
// writes and window jobs into the queue. Depends on cwsm_pkg and cwsm_in_if.
`default_nettype none
module cwsm_front #(
  parameter int MAX_RADIUS = 63
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  cwsm_in_if.sink                        in_ch,
  input  wire logic [cwsm_pkg::CFG_W-1:0] radius,
  input  wire logic                      mean_mode,
  input  wire logic                      q_full,
  output logic                           q_push,
  output cwsm_pkg::cmd_t                 q_data
);
  import cwsm_pkg::*;

  localparam int RD = 2 * MAX_RADIUS + 2;
  localparam int PW = $clog2(RD);
  localparam int CW = $clog2(RD + 1);
  localparam int XW = CW + 1;

  front_state_t   state_r, state_nxt;
  logic [PW-1:0]  wp_r;
  logic [CW-1:0]  seen_r, pending_r;
  logic           last_r;

  logic [CW-1:0]  r_eff, idx, left, right;
  logic [XW-1:0]  centre_x, base_x, n_x;
  logic           known, emit, acc;

  // clamp radius
  always_comb begin
    if ({3'b0, radius} > 9'(MAX_RADIUS)) r_eff = CW'(MAX_RADIUS);
    else                                 r_eff = CW'(radius);
  end

  // window geometry of the oldest owed result
  always_comb begin
    known    = (seen_r < CW'(RD));
    idx      = seen_r - pending_r;
    left     = (known && (idx < r_eff)) ? idx : r_eff;
    right    = ((pending_r - 1'b1) < r_eff) ? (pending_r - 1'b1) : r_eff;
    n_x      = XW'(left) + XW'(right) + 1'b1;
    centre_x = XW'(wp_r) + XW'(RD) - XW'(pending_r);
    if (centre_x >= XW'(RD)) centre_x = centre_x - XW'(RD);
    base_x   = centre_x + XW'(RD) - XW'(left);
    if (base_x >= XW'(RD)) base_x = base_x - XW'(RD);
    emit     = (pending_r != '0) && (last_r || (pending_r > r_eff));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_ACCEPT: if (acc) state_nxt = F_EMIT;
      F_EMIT:   if (!emit) state_nxt = F_ACCEPT;
      default:  state_nxt = F_ACCEPT;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = (state_r == F_ACCEPT) && !q_full;
    acc         = in_ch.valid && in_ch.ready;
    q_push      = 1'b0;
    q_data      = '0;
    case (state_r)
      F_ACCEPT: begin
        q_push        = acc;
        q_data.kind   = CMD_WRITE;
        q_data.slot   = SLOT_W'(wp_r);
        q_data.sample = in_ch.sample;
      end
      F_EMIT: begin
        q_push      = emit && !q_full;
        q_data.kind = CMD_JOB;
        q_data.slot = SLOT_W'(base_x);
        q_data.cnt  = CNT_W'(n_x);
        q_data.mean = mean_mode;
        q_data.last = last_r && (pending_r == CW'(1));
      end
      default: ;
    endcase
  end

  // hold sequence counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_ACCEPT;
      wp_r      <= '0;
      seen_r    <= '0;
      pending_r <= '0;
      last_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        wp_r   <= (wp_r == PW'(RD - 1)) ? '0 : wp_r + 1'b1;
        last_r <= in_ch.last_sample;
        if (seen_r < CW'(RD))    seen_r    <= seen_r + 1'b1;
        if (pending_r < CW'(RD)) pending_r <= pending_r + 1'b1;
      end else if (state_r == F_EMIT) begin
        if (emit && !q_full) begin
          pending_r <= pending_r - 1'b1;
        end else if (!emit && last_r) begin
          wp_r      <= '0;
          seen_r    <= '0;
          pending_r <= '0;
          last_r    <= 1'b0;
        end
      end
    end
  end

  a_pending_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CW'(RD)) else $error("pending above ring depth");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_EMIT && !emit && last_r) |=> (pending_r == '0 && seen_r == '0))
    else $error("sequence not cleared after flush");

endmodule
`default_nettype wire

>>> rtl/cwsm_back.sv
// Back part: holds the sample ring, sums each window one slot per cycle,
// divides for mean mode and drives the result register. Depends on cwsm_pkg.
`default_nettype none
module cwsm_back #(
  parameter int MAX_RADIUS = 63
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire cwsm_pkg::cmd_t q_data,
  output logic                q_pop,
  cwsm_out_if.source          out_ch
);
  import cwsm_pkg::*;

  localparam int RD = 2 * MAX_RADIUS + 2;
  localparam int PW = $clog2(RD);
  localparam int SUM_W = SAMPLE_W + PW + 1;
  // keep room for the saturation compare at any ring size
  localparam int AW = (SUM_W > RESULT_W) ? SUM_W : RESULT_W + 1;
  localparam int DW = $clog2(AW + 1);
  localparam int SW = CNT_W + 1;

  back_state_t            state_r, state_nxt;
  logic [SAMPLE_W-1:0]    ring_r [RD];
  logic [SAMPLE_W-1:0]    rd_r;
  logic                   rdv_r;
  logic [PW-1:0]          addr_r;
  logic [CNT_W-1:0]       iss_r, n_r;
  logic signed [AW-1:0]   acc_r;
  logic                   last_r, mean_r, neg_r;
  logic [AW-1:0]          quo_r;
  logic [SW-1:0]          rem_r;
  logic [DW-1:0]          step_r;
  logic                   out_valid_r, out_last_r;
  logic [RESULT_W-1:0]    out_val_r;

  logic                   sum_done, out_free;
  logic [SW-1:0]          rem_sh;
  logic signed [AW-1:0]   fin;
  logic [RESULT_W-1:0]    sat;

  assign sum_done = (iss_r == n_r) && !rdv_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign rem_sh   = {rem_r[SW-2:0], quo_r[AW-1]};

  // pick final value and saturate to the result range
  always_comb begin
    if (mean_r) fin = neg_r ? -$signed(quo_r) : $signed(quo_r);
    else        fin = acc_r;
    if (fin > AW'(signed'(24'sd4194303)))       sat = {1'b0, {(RESULT_W-1){1'b1}}};
    else if (fin < AW'(signed'(-24'sd4194304))) sat = {1'b1, {(RESULT_W-1){1'b0}}};
    else                                        sat = fin[RESULT_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty && q_data.kind == CMD_JOB) state_nxt = B_SUM;
      B_SUM:  if (sum_done) state_nxt = mean_r ? B_DIV : B_OUT;
      B_DIV:  if (step_r == '0) state_nxt = B_OUT;
      B_OUT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    case (state_r)
      B_IDLE:  q_pop = !q_empty;
      default: q_pop = 1'b0;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.last_result  = out_last_r;

  // ring write and registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == CMD_WRITE) begin
      ring_r[q_data.slot[PW-1:0]] <= q_data.sample;
    end
    rd_r <= ring_r[addr_r];
  end

  // sum, divide and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // raise valid on a new result, drop it once taken
      if (state_r == B_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)            out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_pop && q_data.kind == CMD_JOB) begin
            addr_r <= q_data.slot[PW-1:0];
            n_r    <= q_data.cnt;
            last_r <= q_data.last;
            mean_r <= q_data.mean;
            iss_r  <= '0;
            acc_r  <= '0;
            rdv_r  <= 1'b0;
          end
        end
        B_SUM: begin
          if (iss_r != n_r) begin
            iss_r  <= iss_r + 1'b1;
            addr_r <= (addr_r == PW'(RD - 1)) ? '0 : addr_r + 1'b1;
          end
          rdv_r <= (iss_r != n_r);
          if (rdv_r) acc_r <= acc_r + AW'($signed(rd_r));
          if (sum_done) begin
            neg_r  <= acc_r[AW-1];
            quo_r  <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
            rem_r  <= '0;
            step_r <= DW'(AW);
          end
        end
        B_DIV: begin
          if (step_r != '0) begin
            step_r <= step_r - 1'b1;
            if (rem_sh >= SW'(n_r)) begin
              rem_r <= rem_sh - SW'(n_r);
              quo_r <= {quo_r[AW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[AW-2:0], 1'b0};
            end
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_val_r   <= sat;
            out_last_r  <= last_r;
          end
        end
        default: ;
      endcase
    end
  end

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.kind == CMD_JOB) |-> (q_data.cnt != '0))
    else $error("window job with no samples");
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SUM) |-> (iss_r <= n_r)) else $error("read past window");

endmodule
`default_nettype wire

>>> rtl/centered_window_sum_mean_top.sv
// The front accepts a sample, then issues the results that the sample releases
// and returns to accepting. The back pops each job, sums its n-sample window
// through the single ring read port, in mean mode divides the sum by n in the
// bit-serial divider (sum width at least RESULT_W+1), registers the result and
// only then pops its next command. Results lag the input by radius samples; the
// sample flagged last flushes all owed results.
// Top level: config registers, front, queue and back.
// Depends on cwsm_pkg, cwsm_in_if, cwsm_out_if, cwsm_front, cwsm_queue, cwsm_back.
`default_nettype none
module centered_window_sum_mean_top #(
  parameter int MAX_RADIUS = 63
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cwsm_in_if.sink                            in_ch,
  cwsm_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [cwsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cwsm_pkg::CFG_W-1:0]    cfg_wdata
);
  import cwsm_pkg::*;

  logic [CFG_W-1:0] radius_r;
  logic             mean_mode_r;
  logic             q_full, q_empty, q_push, q_pop;
  cmd_t             q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= CFG_W'(1);
      mean_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:    radius_r    <= cfg_wdata;
        REG_MEAN_MODE: mean_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cwsm_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk, .rst_n, .in_ch,
    .radius(radius_r), .mean_mode(mean_mode_r),
    .q_full, .q_push, .q_data(q_in)
  );

  cwsm_queue u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  cwsm_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop, .out_ch
  );

endmodule
`default_nettype wire
